@@ hw/rtl/fcsg_pkg.sv @@
package fcsg_pkg;

    // Default coordinate width of the center and diameter fields.
    localparam int COORD_BITS_DEFAULT = 16;

    // Width of the packed RGBA fill color.
    localparam int COLOR_BITS = 32;

    // Number of step records that may wait between the front and the back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Step record: {color, done, outer, inner, origin_y, origin_x}, origin_x lowest.
    function automatic int rec_bits(input int coord_bits);
        return 4 * coord_bits + 2 + 1 + COLOR_BITS;
    endfunction

endpackage

@@ hw/rtl/fcsg_queue.sv @@
module fcsg_queue
    import fcsg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;

    // The extra pointer bit tells a full queue from an empty one.
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign head_data = mem_reg[rd_ptr_reg[AW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_data;
        end
    end

endmodule

@@ hw/rtl/fcsg_front.sv @@
module fcsg_front
    import fcsg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int REC_BITS = rec_bits(COORD_BITS)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [COLOR_BITS-1:0]        cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_action,
    input  logic signed [COORD_BITS-1:0] in_center_x,
    input  logic signed [COORD_BITS-1:0] in_center_y,
    input  logic [COORD_BITS-1:0]        in_diameter,
    input  logic                         q_full,
    output logic                         push,
    output logic [REC_BITS-1:0]          rec
);

    localparam int OFF_W = COORD_BITS + 1;
    localparam int DEC_W = COORD_BITS + 3;
    localparam int RAD_W = COORD_BITS - 1;
    localparam logic signed [DEC_W-1:0] ONE_D = 1;
    localparam logic signed [OFF_W-1:0] ONE_O = 1;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    logic [COLOR_BITS-1:0]        color_reg;
    logic                         busy_reg;
    logic                         busy_next;
    logic signed [COORD_BITS-1:0] origin_x_reg;
    logic signed [COORD_BITS-1:0] origin_x_next;
    logic signed [COORD_BITS-1:0] origin_y_reg;
    logic signed [COORD_BITS-1:0] origin_y_next;
    logic [RAD_W-1:0]             radius_reg;
    logic [RAD_W-1:0]             radius_next;
    logic signed [OFF_W-1:0]      ix_reg;
    logic signed [OFF_W-1:0]      ix_next;
    logic signed [OFF_W-1:0]      ox_reg;
    logic signed [OFF_W-1:0]      ox_next;
    logic signed [DEC_W-1:0]      dec_reg;
    logic signed [DEC_W-1:0]      dec_next;

    logic                         accept;
    logic                         active;
    logic signed [DEC_W-1:0]      ix_w;
    logic signed [DEC_W-1:0]      ox_w;
    logic signed [DEC_W-1:0]      rad_w;
    logic signed [DEC_W-1:0]      rmo;
    logic signed [DEC_W-1:0]      two_ix;
    logic signed [DEC_W-1:0]      two_ox;
    logic signed [DEC_W-1:0]      two_rmo;
    logic signed [DEC_W-1:0]      gap;
    logic signed [DEC_W-1:0]      two_gap;
    logic signed [DEC_W-1:0]      start_dec;
    logic                         done;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    // A circle is still active while the outer offset has not passed the inner one.
    assign active   = busy_reg && !(ox_reg < ix_reg);

    always_comb
    begin
        ix_w    = $signed({{(DEC_W-OFF_W){ix_reg[OFF_W-1]}}, ix_reg});
        ox_w    = $signed({{(DEC_W-OFF_W){ox_reg[OFF_W-1]}}, ox_reg});
        rad_w   = $signed({{(DEC_W-RAD_W){1'b0}}, radius_reg});
        rmo     = rad_w - ox_w;
        gap     = ox_w - ix_w - ONE_D;
        two_ix  = $signed({ix_w[DEC_W-2:0], 1'b0});
        two_ox  = $signed({ox_w[DEC_W-2:0], 1'b0});
        two_rmo = $signed({rmo[DEC_W-2:0], 1'b0});
        two_gap = $signed({gap[DEC_W-2:0], 1'b0});
        start_dec = $signed({{(DEC_W-RAD_W){1'b0}}, in_diameter[COORD_BITS-1:1]}) - ONE_D;

        busy_next     = busy_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        radius_next   = radius_reg;
        ix_next       = ix_reg;
        ox_next       = ox_reg;
        dec_next      = dec_reg;
        push          = 1'b0;

        if (dec_reg >= two_ix)
        begin
            dec_next = dec_reg - two_ix - ONE_D;
            ix_next  = ix_reg + ONE_O;
        end
        else if (dec_reg < two_rmo)
        begin
            dec_next = dec_reg + two_ox - ONE_D;
            ox_next  = ox_reg - ONE_O;
        end
        else
        begin
            dec_next = dec_reg + two_gap;
            ox_next  = ox_reg - ONE_O;
            ix_next  = ix_reg + ONE_O;
        end
        done = (ox_next < ix_next);

        if (!accept || (action_t'(in_action) == ACT_STEP && !active))
        begin
            // Nothing to do: the moves above are discarded.
            ix_next  = ix_reg;
            ox_next  = ox_reg;
            dec_next = dec_reg;
            if (accept)
            begin
                busy_next = 1'b0;
            end
        end
        else if (action_t'(in_action) == ACT_START)
        begin
            origin_x_next = in_center_x;
            origin_y_next = in_center_y;
            radius_next   = in_diameter[COORD_BITS-1:1];
            ix_next       = '0;
            ox_next       = $signed({2'b00, in_diameter[COORD_BITS-1:1]});
            dec_next      = start_dec;
            busy_next     = 1'b1;
        end
        else
        begin
            push      = 1'b1;
            busy_next = !done;
        end

        rec = {color_reg, done, ox_reg, ix_reg, origin_y_reg, origin_x_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg    <= '0;
            busy_reg     <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            radius_reg   <= '0;
            ix_reg       <= '0;
            ox_reg       <= '0;
            dec_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
            busy_reg     <= busy_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            radius_reg   <= radius_next;
            ix_reg       <= ix_next;
            ox_reg       <= ox_next;
            dec_reg      <= dec_next;
        end
    end

endmodule

@@ hw/rtl/fcsg_back.sv @@
module fcsg_back
    import fcsg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int REC_BITS = rec_bits(COORD_BITS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [REC_BITS-1:0]        rec,
    input  logic                       q_empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_BITS:0] span_y,
    output logic signed [COORD_BITS:0] span_x_left,
    output logic signed [COORD_BITS:0] span_x_right,
    output logic [COLOR_BITS-1:0]      span_color,
    output logic                       last_of_step,
    output logic                       circle_done
);

    localparam int C = COORD_BITS;

    typedef enum logic [1:0] {
        PH_INNER_POS,
        PH_OUTER_POS,
        PH_OUTER_NEG,
        PH_INNER_NEG
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic                  valid_reg;
    logic signed [C:0]     y_reg;
    logic signed [C:0]     xl_reg;
    logic signed [C:0]     xr_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  last_reg;
    logic                  done_reg;

    logic                  load;
    logic signed [C:0]     x_e;
    logic signed [C:0]     y_e;
    logic signed [C:0]     ix;
    logic signed [C:0]     ox;
    logic                  rec_done;
    logic [COLOR_BITS-1:0] rec_color;
    logic signed [C:0]     y_sel;
    logic signed [C:0]     xl_sel;
    logic signed [C:0]     xr_sel;
    logic                  last_sel;

    assign x_e       = $signed({rec[C-1], rec[C-1:0]});
    assign y_e       = $signed({rec[2*C-1], rec[2*C-1:C]});
    assign ix        = $signed(rec[3*C:2*C]);
    assign ox        = $signed(rec[4*C+1:3*C+1]);
    assign rec_done  = rec[4*C+2];
    assign rec_color = rec[4*C+2+COLOR_BITS:4*C+3];

    // The output register loads a queued span when it is empty or being drained.
    assign load = !q_empty && (!valid_reg || out_ready);
    assign pop  = load && (phase_reg == PH_INNER_NEG);

    always_comb
    begin
        unique case (phase_reg)
            PH_INNER_POS:
            begin
                y_sel      = y_e + ix;
                xl_sel     = x_e - ox;
                xr_sel     = x_e + ox;
                last_sel   = 1'b0;
                phase_next = PH_OUTER_POS;
            end
            PH_OUTER_POS:
            begin
                y_sel      = y_e + ox;
                xl_sel     = x_e - ix;
                xr_sel     = x_e + ix;
                last_sel   = 1'b0;
                phase_next = PH_OUTER_NEG;
            end
            PH_OUTER_NEG:
            begin
                y_sel      = y_e - ox;
                xl_sel     = x_e - ix;
                xr_sel     = x_e + ix;
                last_sel   = 1'b0;
                phase_next = PH_INNER_NEG;
            end
            PH_INNER_NEG:
            begin
                y_sel      = y_e - ix;
                xl_sel     = x_e - ox;
                xr_sel     = x_e + ox;
                last_sel   = 1'b1;
                phase_next = PH_INNER_POS;
            end
            default:
            begin
                y_sel      = y_e;
                xl_sel     = x_e;
                xr_sel     = x_e;
                last_sel   = 1'b0;
                phase_next = PH_INNER_POS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INNER_POS;
            valid_reg <= 1'b0;
            y_reg     <= '0;
            xl_reg    <= '0;
            xr_reg    <= '0;
            color_reg <= '0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (load)
        begin
            phase_reg <= phase_next;
            valid_reg <= 1'b1;
            y_reg     <= y_sel;
            xl_reg    <= xl_sel;
            xr_reg    <= xr_sel;
            color_reg <= rec_color;
            last_reg  <= last_sel;
            done_reg  <= last_sel && rec_done;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid    = valid_reg;
    assign span_y       = y_reg;
    assign span_x_left  = xl_reg;
    assign span_x_right = xr_reg;
    assign span_color   = color_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

@@ hw/rtl/filled_circle_span_generator_top.sv @@
// Filled circle span generator.
//
// The slave channel takes commands: tuser = 0 starts a circle from the center and
// diameter in tdata, tuser = 1 advances it by one iteration. The master channel
// gives horizontal spans, four per iteration; tlast marks the fourth span of an
// iteration and tuser marks the last span of the whole circle. cfg_we writes the
// fill color, which is copied onto every span of the following steps.
//
// A start gives no transfer. A step is classified and its record written into the
// queue; its first span is then loaded into the output register, and the other
// three follow one per cycle while m_tready stays high. The master channel sets
// the sustained rate, and a queue of QUEUE_DEPTH steps lets a burst of commands
// in at one per cycle until it is full. Steps on an idle or finished circle give
// nothing.
//
// Reset clears the circle state, the color, the queue and the output register.
// When the receiver stalls, the held span stays put, the queue fills and s_tready
// drops once it is full.
module filled_circle_span_generator_top
    import fcsg_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [COLOR_BITS-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // center_x, center_y, diameter, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // span_y, span_x_left, span_x_right, span_color, zero fill
    output logic [((3*(COORD_BITS+1)+COLOR_BITS+7)/8)*8-1:0] m_tdata,
    // last_of_step
    output logic                   m_tlast,
    // circle_done
    output logic                   m_tuser
);

    localparam int REC_BITS = rec_bits(COORD_BITS);
    localparam int OUT_BITS = ((3*(COORD_BITS+1)+COLOR_BITS+7)/8)*8;

    logic                         q_push;
    logic                         q_full;
    logic                         q_pop;
    logic                         q_empty;
    logic [REC_BITS-1:0]          q_in;
    logic [REC_BITS-1:0]          q_head;
    logic signed [COORD_BITS:0]   span_y;
    logic signed [COORD_BITS:0]   span_x_left;
    logic signed [COORD_BITS:0]   span_x_right;
    logic [COLOR_BITS-1:0]        span_color;

    fcsg_front #(
        .COORD_BITS (COORD_BITS),
        .REC_BITS   (REC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_center_x ($signed(s_tdata[COORD_BITS-1:0])),
        .in_center_y ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .in_diameter (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .q_full      (q_full),
        .push        (q_push),
        .rec         (q_in)
    );

    fcsg_queue #(
        .WIDTH (REC_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty)
    );

    fcsg_back #(
        .COORD_BITS (COORD_BITS),
        .REC_BITS   (REC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (q_head),
        .q_empty      (q_empty),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .span_y       (span_y),
        .span_x_left  (span_x_left),
        .span_x_right (span_x_right),
        .span_color   (span_color),
        .last_of_step (m_tlast),
        .circle_done  (m_tuser)
    );

    assign m_tdata = OUT_BITS'({span_color, span_x_right, span_x_left, span_y});

    // The end of a circle always falls on the last span of a step.
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("circle end flagged on a span that does not close a step");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("step record pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("step record popped from an empty queue");

    // A span held under back-pressure must not change its step flags.
    a_hold_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output span changed while stalled");

endmodule
